// ----- rtl/ic2d_pkg.sv -----
// ic2d_pkg: shared types and codes for the 2-d convolution unit
// no dependencies

package ic2d_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN,
    ST_ROUND
  } state_t;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_KERNEL_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_KERNEL_HEIGHT = 2'd3;

  localparam int COEF_BITS = 16;
  localparam int OUT_BITS  = 24;
  localparam int DIM_BITS  = 11;
  localparam int KDIM_BITS = 3;

endpackage

// ----- rtl/image_convolution_2d_unit.sv -----
// image_convolution_2d_unit: streaming zero-padded 2-d convolution, one shared mac
// depends on ic2d_pkg
//
// Usage: configure geometry through cfg_write/cfg_index/cfg_data while idle; any
// write restarts the frame. Input words carry a command: load coefficient (Q7.8
// into the coefficient store), pixel sample (raster order into a row store of
// MAX_KERNEL+1 lines), or drain (flush one pending result after the frame).
// A pixel yields a result once center_row*width+center_col further pixels have
// arrived; drains give the tail. frame_end marks the last result of a frame.
// A word that yields a result is walked through the taps by the single
// multiply-accumulate, one tap per cycle, into the output register; item_stall
// is high meanwhile. Load words and other words with no result leave it idle.
// The output register holds a finished word while result_stall is high; the
// next item is accepted meanwhile and its result waits until that word leaves.
// Reset (rst, synchronous) clears the counters and restores 640x480 with a 3x3
// kernel; coefficient and row stores are not cleared.

module image_convolution_2d_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7,
  parameter int PIXEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [ic2d_pkg::DIM_BITS-1:0]     cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        command,
  input  logic [5:0]                        coef_index,
  input  logic signed [ic2d_pkg::COEF_BITS-1:0] coef_value,
  input  logic [PIXEL_BITS-1:0]             pixel,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [ic2d_pkg::OUT_BITS-1:0] filtered_value,
  output logic                              frame_end
);

  localparam int ROW_LINES  = MAX_KERNEL + 1;
  localparam int ROW_DEPTH  = ROW_LINES * MAX_WIDTH;
  localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int LB  = $clog2(ROW_LINES);
  localparam int AW  = $clog2(ROW_DEPTH);
  localparam int XB  = $clog2(MAX_WIDTH);
  localparam int WB  = XB + 1;
  localparam int CW  = XB + ic2d_pkg::DIM_BITS + 1;
  localparam int KB  = $clog2(MAX_KERNEL + 1);
  localparam int CAB = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int RW  = ic2d_pkg::DIM_BITS + 2;
  localparam int CLW = XB + 2;
  localparam int PW  = ic2d_pkg::COEF_BITS + PIXEL_BITS + 1;
  localparam int ACW = PW + $clog2(COEF_DEPTH + 1) + 1;
  localparam int OB  = ic2d_pkg::OUT_BITS;

  ic2d_pkg::state_t state, state_next;

  logic [ic2d_pkg::DIM_BITS-1:0]  image_width, image_height;
  logic [ic2d_pkg::KDIM_BITS-1:0] kernel_width, kernel_height;

  logic [PIXEL_BITS-1:0]                 row_mem [ROW_DEPTH];
  logic signed [ic2d_pkg::COEF_BITS-1:0] coef_mem [COEF_DEPTH];

  logic [CW-1:0]                  pix_cnt, res_cnt;
  logic [XB-1:0]                  pix_col, res_col;
  logic [ic2d_pkg::DIM_BITS-1:0]  res_row;
  logic [LB-1:0]                  pix_line, res_line;

  logic [KB-1:0]         tap_m, tap_n;
  logic signed [RW-1:0]  tap_row;
  logic signed [CLW-1:0] tap_col;
  logic [LB-1:0]         tap_line;
  logic [CAB-1:0]        coef_addr;

  logic                              v1, ok1, v2;
  logic [PIXEL_BITS-1:0]             pix_q;
  logic signed [ic2d_pkg::COEF_BITS-1:0] coef_q;
  logic signed [PW-1:0]              prod;
  logic signed [ACW-1:0]             acc;

  logic [WB-1:0] ew;
  logic [ic2d_pkg::DIM_BITS-1:0] eh;
  logic [KB-1:0] ekw, ekh, cx, cy;
  logic [CW-1:0] total, lag;
  logic [CW:0]   res_plus_lag;
  logic          accept, go, pix_take, tap_ok, tap_last, emit_load, last;
  logic [LB:0]   line_sum;
  logic [LB-1:0] line_start;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [ACW-1:0] mag;
  logic [ACW-1:0] rnd;
  logic signed [OB-1:0] res_val;

  always_comb begin
    if (image_width == '0) begin
      ew = WB'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      ew = WB'(MAX_WIDTH);
    end else begin
      ew = WB'(image_width);
    end
    eh = (image_height == '0) ? ic2d_pkg::DIM_BITS'(1) : image_height;
    if (kernel_width == '0) begin
      ekw = KB'(1);
    end else if (32'(kernel_width) > MAX_KERNEL) begin
      ekw = KB'(MAX_KERNEL);
    end else begin
      ekw = KB'(kernel_width);
    end
    if (kernel_height == '0) begin
      ekh = KB'(1);
    end else if (32'(kernel_height) > MAX_KERNEL) begin
      ekh = KB'(MAX_KERNEL);
    end else begin
      ekh = KB'(kernel_height);
    end
    cx = ekw >> 1;
    cy = ekh >> 1;
    total = CW'(ew) * CW'(eh);
    lag = CW'(cy) * CW'(ew) + CW'(cx);
    res_plus_lag = {1'b0, res_cnt} + {1'b0, lag};
  end

  always_comb begin
    accept = item_valid && !item_stall;
    pix_take = accept && command == ic2d_pkg::CMD_PIXEL && pix_cnt < total;
    go = 1'b0;
    if (accept) begin
      case (command)
        ic2d_pkg::CMD_PIXEL: go = pix_take && res_plus_lag <= {1'b0, pix_cnt} &&
                                  res_cnt < total;
        ic2d_pkg::CMD_DRAIN: go = pix_cnt >= total && res_cnt < total;
        default:             go = 1'b0;
      endcase
    end
    tap_ok = tap_row >= 0 && tap_row < $signed({2'b0, eh}) &&
             tap_col >= 0 && tap_col < $signed(CLW'(ew));
    tap_last = tap_m == ekh - KB'(1) && tap_n == ekw - KB'(1);
    line_sum = {1'b0, res_line} + (LB+1)'(cy);
    line_start = (32'(line_sum) >= ROW_LINES) ? LB'(32'(line_sum) - ROW_LINES)
                                              : LB'(line_sum);
    wr_addr = AW'(pix_line) * AW'(MAX_WIDTH) + AW'(pix_col);
    rd_addr = tap_ok ? AW'(tap_line) * AW'(MAX_WIDTH) + AW'(tap_col[XB-1:0]) : '0;
    last = CW'(res_cnt + CW'(1)) >= total;
  end

  always_comb begin
    mag = acc[ACW-1] ? ACW'(-acc) : ACW'(acc);
    rnd = (mag + ACW'(128)) >> 8;
    if (acc[ACW-1]) begin
      res_val = (rnd >= ACW'(1 << (OB-1))) ? {1'b1, {(OB-1){1'b0}}} : OB'(-rnd);
    end else begin
      res_val = (rnd >= ACW'(1 << (OB-1))) ? {1'b0, {(OB-1){1'b1}}} : OB'(rnd);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ic2d_pkg::ST_IDLE:  if (go) state_next = ic2d_pkg::ST_TAP;
      ic2d_pkg::ST_TAP:   if (tap_last) state_next = ic2d_pkg::ST_DRAIN;
      ic2d_pkg::ST_DRAIN: if (!v1 && !v2) state_next = ic2d_pkg::ST_ROUND;
      ic2d_pkg::ST_ROUND: if (emit_load) state_next = ic2d_pkg::ST_IDLE;
      default:            state_next = ic2d_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall = 1'b1;
    emit_load  = 1'b0;
    case (state)
      ic2d_pkg::ST_IDLE:  item_stall = 1'b0;
      ic2d_pkg::ST_ROUND: emit_load = !result_valid || !result_stall;
      default: begin
        item_stall = 1'b1;
        emit_load  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ic2d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (pix_take) begin
      row_mem[wr_addr] <= pixel;
    end
    if (accept && command == ic2d_pkg::CMD_LOAD && 32'(coef_index) < COEF_DEPTH) begin
      coef_mem[CAB'(coef_index)] <= coef_value;
    end
    pix_q  <= row_mem[rd_addr];
    coef_q <= coef_mem[coef_addr];
  end

  // configuration and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= ic2d_pkg::DIM_BITS'(640);
      image_height  <= ic2d_pkg::DIM_BITS'(480);
      kernel_width  <= ic2d_pkg::KDIM_BITS'(3);
      kernel_height <= ic2d_pkg::KDIM_BITS'(3);
      pix_cnt <= '0; pix_col <= '0; pix_line <= '0;
      res_cnt <= '0; res_col <= '0; res_row <= '0; res_line <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ic2d_pkg::CFG_IMAGE_WIDTH:   image_width <= cfg_data;
          ic2d_pkg::CFG_IMAGE_HEIGHT:  image_height <= cfg_data;
          ic2d_pkg::CFG_KERNEL_WIDTH:  kernel_width <= cfg_data[ic2d_pkg::KDIM_BITS-1:0];
          ic2d_pkg::CFG_KERNEL_HEIGHT: kernel_height <= cfg_data[ic2d_pkg::KDIM_BITS-1:0];
          default: ;
        endcase
        pix_cnt <= '0; pix_col <= '0; pix_line <= '0;
        res_cnt <= '0; res_col <= '0; res_row <= '0; res_line <= '0;
      end else begin
        if (pix_take) begin
          pix_cnt <= pix_cnt + CW'(1);
          if (WB'(pix_col) == ew - WB'(1)) begin
            pix_col  <= '0;
            pix_line <= (32'(pix_line) == ROW_LINES - 1) ? '0 : pix_line + LB'(1);
          end else begin
            pix_col <= pix_col + XB'(1);
          end
        end
        if (emit_load) begin
          if (last) begin
            pix_cnt <= '0; pix_col <= '0; pix_line <= '0;
            res_cnt <= '0; res_col <= '0; res_row <= '0; res_line <= '0;
          end else begin
            res_cnt <= res_cnt + CW'(1);
            if (WB'(res_col) == ew - WB'(1)) begin
              res_col  <= '0;
              res_row  <= res_row + ic2d_pkg::DIM_BITS'(1);
              res_line <= (32'(res_line) == ROW_LINES - 1) ? '0 : res_line + LB'(1);
            end else begin
              res_col <= res_col + XB'(1);
            end
          end
        end
      end
      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      filtered_value <= res_val;
      frame_end      <= last;
    end
  end

  // tap walk and mac pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= state == ic2d_pkg::ST_TAP;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ok1 <= tap_ok;
    prod <= ok1 ? PW'(coef_q * $signed({1'b0, pix_q})) : '0;
    if (go) begin
      tap_m     <= '0;
      tap_n     <= '0;
      tap_row   <= $signed({2'b0, res_row}) + RW'(cy);
      tap_col   <= $signed({2'b0, res_col}) + CLW'(cx);
      tap_line  <= line_start;
      coef_addr <= '0;
      acc       <= '0;
    end else begin
      if (state == ic2d_pkg::ST_TAP) begin
        coef_addr <= coef_addr + CAB'(1);
        if (tap_n == ekw - KB'(1)) begin
          tap_n    <= '0;
          tap_m    <= tap_m + KB'(1);
          tap_row  <= tap_row - RW'(1);
          tap_col  <= $signed({2'b0, res_col}) + CLW'(cx);
          tap_line <= (tap_line == '0) ? LB'(ROW_LINES - 1) : tap_line - LB'(1);
        end else begin
          tap_n   <= tap_n + KB'(1);
          tap_col <= tap_col - CLW'(1);
        end
      end
      if (v2) begin
        acc <= acc + ACW'(prod);
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for image_convolution_2d_unit, driven through its command stream
// depends on ic2d_pkg and the unit rtl; a built-in predictor computes each filtered word

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 1024;
  localparam int MAXK = 7;
  localparam int LINES = MAXK + 1;
  localparam int CDEPTH = MAXK * MAXK;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [ic2d_pkg::OUT_BITS-1:0] value;
    logic                                 last;
  } conv_word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [ic2d_pkg::DIM_BITS-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic [1:0] command;
  logic [5:0] coef_index;
  logic signed [ic2d_pkg::COEF_BITS-1:0] coef_value;
  logic [7:0] pixel;
  logic result_valid;
  logic result_stall;
  logic signed [ic2d_pkg::OUT_BITS-1:0] filtered_value;
  logic frame_end;

  image_convolution_2d_unit u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0] line_buf [LINES*MAXW];
  logic signed [ic2d_pkg::COEF_BITS-1:0] taps [CDEPTH];
  int unsigned px_count, out_count;
  int unsigned img_w, img_h, ker_w, ker_h;
  conv_word_t conv_queue[$];

  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  longint cycles = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned ew(); return clampv(img_w, MAXW); endfunction
  function automatic int unsigned eh(); return clampv(img_h, 2047); endfunction
  function automatic int unsigned ekw(); return clampv(ker_w, MAXK); endfunction
  function automatic int unsigned ekh(); return clampv(ker_h, MAXK); endfunction

  function automatic logic signed [ic2d_pkg::OUT_BITS-1:0] convolve_at(int unsigned q);
    int w, h, kw, kh, i, j, cy, cx, r, c;
    longint acc, mag, res;
    w = ew(); h = eh(); kw = ekw(); kh = ekh();
    i = q / w; j = q % w; cy = kh / 2; cx = kw / 2;
    acc = 0;
    for (int m = 0; m < kh; m++) begin
      r = i + cy - m;
      if (r < 0 || r >= h) continue;
      for (int n = 0; n < kw; n++) begin
        c = j + cx - n;
        if (c < 0 || c >= w) continue;
        acc += longint'(taps[m*kw+n]) * longint'({1'b0, line_buf[(r % LINES)*MAXW + c]});
      end
    end
    mag = acc < 0 ? -acc : acc;
    mag = (mag + 128) >>> 8;
    if (mag > 64'sd8388608) mag = 64'sd8388608;
    res = acc < 0 ? -mag : mag;
    if (res > 64'sd8388607) res = 64'sd8388607;
    return res[ic2d_pkg::OUT_BITS-1:0];
  endfunction

  function automatic void emit_conv();
    conv_word_t e;
    e.value = convolve_at(out_count);
    out_count++;
    e.last = out_count >= ew() * eh();
    if (e.last) begin
      out_count = 0;
      px_count = 0;
    end
    conv_queue.push_back(e);
  endfunction

  function automatic void predict_word(logic [1:0] cmd, logic [5:0] idx,
                                       logic signed [15:0] val, logic [7:0] pix);
    int unsigned total, lag;
    total = ew() * eh();
    lag = (ekh() / 2) * ew() + ekw() / 2;
    case (cmd)
      ic2d_pkg::CMD_LOAD: if (idx < CDEPTH) taps[idx] = val;
      ic2d_pkg::CMD_PIXEL: begin
        if (px_count < total) begin
          line_buf[((px_count / ew()) % LINES)*MAXW + px_count % ew()] = pix;
          px_count++;
          if (out_count + lag < px_count && out_count < total) emit_conv();
        end
      end
      ic2d_pkg::CMD_DRAIN: if (px_count >= total && out_count < total) emit_conv();
      default: ;
    endcase
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [5:0] idx, logic [15:0] val,
                           logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    command <= cmd;
    coef_index <= idx;
    coef_value <= val;
    pixel <= pix;
    do @(posedge clk); while (item_stall);
    predict_word(cmd, idx, val, pix);
    items_sent++;
  endtask

  task automatic send_pixel(logic [7:0] pix);
    send_word(ic2d_pkg::CMD_PIXEL, 6'($urandom), 16'($urandom), pix);
  endtask

  task automatic send_drain();
    send_word(ic2d_pkg::CMD_DRAIN, 6'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (conv_queue.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ic2d_pkg::DIM_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      ic2d_pkg::CFG_IMAGE_WIDTH: img_w = data;
      ic2d_pkg::CFG_IMAGE_HEIGHT: img_h = data;
      ic2d_pkg::CFG_KERNEL_WIDTH: ker_w = data[ic2d_pkg::KDIM_BITS-1:0];
      default: ker_h = data[ic2d_pkg::KDIM_BITS-1:0];
    endcase
    px_count = 0;
    out_count = 0;
  endtask

  task automatic set_geometry(int w, int h, int kw, int kh);
    settle();
    write_reg(ic2d_pkg::CFG_IMAGE_WIDTH, ic2d_pkg::DIM_BITS'(w));
    write_reg(ic2d_pkg::CFG_IMAGE_HEIGHT, ic2d_pkg::DIM_BITS'(h));
    write_reg(ic2d_pkg::CFG_KERNEL_WIDTH, ic2d_pkg::DIM_BITS'(kw));
    write_reg(ic2d_pkg::CFG_KERNEL_HEIGHT, ic2d_pkg::DIM_BITS'(kh));
    cfg_write <= 1'b0;
  endtask

  // pixels with optional noise, then drains to flush the tail; broken frames stop early
  task automatic run_frame(int noise_pct, bit broken);
    int unsigned total, stop_at;
    int sel;
    total = ew() * eh();
    stop_at = broken ? $urandom_range(0, total - 1) : total;
    for (int unsigned p = 0; p < stop_at; p++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
          send_word(ic2d_pkg::CMD_LOAD, 6'($urandom), 16'($urandom), 8'($urandom));
        end else if (sel == 1) begin
          send_word(CMD_UNUSED, 6'($urandom), 16'($urandom), 8'($urandom));
        end else begin
          send_drain();
        end
      end
      send_pixel(8'($urandom));
    end
    if (broken) return;
    if (px_count != 0 && $urandom_range(0, 3) == 0) send_pixel(8'($urandom));
    while (out_count != 0 || px_count != 0) send_drain();
    if ($urandom_range(0, 3) == 0) send_drain();
  endtask

  task automatic test_coefficients();
    send_word(ic2d_pkg::CMD_LOAD, 6'd0, 16'h7fff, 8'h00);
    send_word(ic2d_pkg::CMD_LOAD, 6'd48, 16'h8000, 8'hff);
    for (int k = 1; k < 48; k++)
      send_word(ic2d_pkg::CMD_LOAD, 6'(k), 16'($urandom_range(0, 16'hffff)),
                8'($urandom));
  endtask

  task automatic test_directed();
    set_geometry(3, 2, 3, 3);
    send_drain();
    send_word(CMD_UNUSED, 6'h3f, 16'hffff, 8'hff);
    send_word(ic2d_pkg::CMD_LOAD, 6'h3f, 16'h1234, 8'h00);
    send_word(ic2d_pkg::CMD_LOAD, 6'd4, 16'h0100, 8'h00);
    send_pixel(8'hff);
    send_pixel(8'h00);
    send_pixel(8'hff);
    send_pixel(8'h80);
    send_pixel(8'h7f);
    send_pixel(8'h01);
    send_pixel(8'hff);
    send_drain();
    send_drain();
    send_drain();
    send_word(ic2d_pkg::CMD_LOAD, 6'd4, 16'h8000, 8'h00);
    send_word(ic2d_pkg::CMD_LOAD, 6'd0, 16'h7fff, 8'h00);
    run_frame(0, 0);
  endtask

  task automatic test_extremes();
    set_geometry(2047, 1, 7, 1);
    run_frame(2, 0);
    set_geometry(1, 40, 0, 7);
    run_frame(2, 0);
    set_geometry(1, 0, 7, 0);
    run_frame(0, 0);
    set_geometry(0, 1, 0, 0);
    run_frame(0, 0);
  endtask

  task automatic test_random();
    while (items_sent < 1400) begin
      set_geometry($urandom_range(1, 12), $urandom_range(1, 8),
                   $urandom_range(0, 7), $urandom_range(0, 7));
      run_frame($urandom_range(0, 15), $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic test_backpressure();
    set_geometry(8, 6, 3, 3);
    settle();
    hold_start = 1'b1;
    run_frame(0, 0);
  endtask

  // receiver: checks each word and stalls on its own pattern
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (conv_queue.size() == 0) begin
          $error("unexpected word: filtered_value %0d", filtered_value);
          errors++;
        end else begin
          if (conv_queue[0].value !== filtered_value) begin
            $error("filtered_value expected %0d actual %0d", conv_queue[0].value,
                   filtered_value);
            errors++;
          end
          if (conv_queue[0].last !== frame_end) begin
            $error("frame_end expected %0d actual %0d", conv_queue[0].last, frame_end);
            errors++;
          end
          void'(conv_queue.pop_front());
        end
      end
      if (hold_start) begin
        hold_left = 600;
        hold_start = 1'b0;
      end
      if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 9) < 3);
          default: result_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    command = '0;
    coef_index = '0;
    coef_value = '0;
    pixel = '0;
    img_w = 640;
    img_h = 480;
    ker_w = 3;
    ker_h = 3;
    px_count = 0;
    out_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_coefficients();
    test_directed();
    test_extremes();
    test_backpressure();
    test_random();
    settle();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ic2d_pkg.sv
rtl/image_convolution_2d_unit.sv
dv/tb.sv
